>>> design/ptoc_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer overrun counter package
// Shared payload types, operation and status codes, and controller types.
// ----------------------------------------------------------------------------
package ptoc_pkg;

    localparam int DEF_TIME_WIDTH = 64;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_GET  = 2'd3;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_WOULD_BLOCK = 2'd1;
    localparam logic [1:0] STATUS_INVALID     = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] now_time;
        logic [63:0] start_value;
        logic [63:0] period_in;
        logic        absolute;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] expiry_count;
        logic [63:0] remaining_time;
        logic [63:0] period_out;
        logic        fired;
        logic        readable;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/ptoc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptoc_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;
    logic [W:0]    trial_diff;
    logic          ge;

    assign trial      = {r_reg, q_reg[W-1]};
    assign trial_diff = trial - {1'b0, d_reg};
    assign ge         = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            r_next    = '0;
            q_next    = dividend;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next = ge ? trial_diff[W-1:0] : trial[W-1:0];
            q_next = {q_reg[W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> design/ptoc_dp.sv
// ----------------------------------------------------------------------------
// Timer datapath
// Holds the timer state, the captured transaction and the result register,
// and evaluates each operation with the help of the serial divider.
// ----------------------------------------------------------------------------
module ptoc_dp #(
    parameter int TIME_WIDTH = ptoc_pkg::DEF_TIME_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptoc_pkg::dp_cmd_t    cmd,
    output ptoc_pkg::dp_status_t status,
    input  ptoc_pkg::item_t      item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ptoc_pkg::result_t    result
);
    import ptoc_pkg::*;

    localparam int TW = TIME_WIDTH;

    logic [1:0]    op_reg;
    logic [TW-1:0] now_reg;
    logic [TW-1:0] start_reg;
    logic [TW-1:0] per_in_reg;
    logic          abs_reg;

    logic          armed_reg, armed_next;
    logic [63:0]   total_reg, total_next;
    logic [TW-1:0] deadline_reg, deadline_next;
    logic [TW-1:0] period_reg, period_next;

    result_t       res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          is_tick, is_set, tick_fire, set_catch, need_div, div_busy;
    logic [TW-1:0] div_dividend, div_divisor, div_q, div_r;
    logic [TW-1:0] q_eff, r_eff, adv;
    logic [TW:0]   rel_sum;
    logic [TW-1:0] rem_old, per_old;

    assign is_tick   = (op_reg == OP_TICK);
    assign is_set    = (op_reg == OP_SET);
    assign tick_fire = armed_reg && (now_reg >= deadline_reg);
    assign set_catch = is_set && (start_reg != '0) && abs_reg && (start_reg <= now_reg);
    assign need_div  = (is_tick && tick_fire && (period_reg != '0))
                    || (set_catch && (per_in_reg != '0));

    assign div_dividend = is_set ? (now_reg - start_reg) : (now_reg - deadline_reg);
    assign div_divisor  = is_set ? per_in_reg : period_reg;

    ptoc_div #(
        .W(TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign q_eff   = need_div ? div_q : '0;
    assign r_eff   = need_div ? div_r : '0;
    assign adv     = now_reg - r_eff + div_divisor;
    assign rel_sum = {1'b0, now_reg} + {1'b0, start_reg};
    assign rem_old = (armed_reg && (deadline_reg > now_reg)) ? (deadline_reg - now_reg) : '0;
    assign per_old = armed_reg ? period_reg : '0;

    always_comb
    begin
        armed_next    = armed_reg;
        total_next    = total_reg;
        deadline_next = deadline_reg;
        period_next   = period_reg;
        res_next      = '0;
        case (op_reg)
            OP_TICK:
            begin
                if (tick_fire)
                begin
                    total_next = total_reg + 64'(q_eff) + 64'd1;
                    if (period_reg != '0)
                    begin
                        deadline_next = adv;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                    end
                    res_next.fired = 1'b1;
                end
                res_next.expiry_count = total_next;
            end
            OP_SET:
            begin
                res_next.remaining_time = 64'(rem_old);
                res_next.period_out     = 64'(per_old);
                armed_next  = 1'b0;
                total_next  = '0;
                period_next = per_in_reg;
                if (start_reg != '0)
                begin
                    if (abs_reg)
                    begin
                        deadline_next = start_reg;
                        if (start_reg > now_reg)
                        begin
                            armed_next = 1'b1;
                        end
                        else
                        begin
                            total_next     = 64'(q_eff) + 64'd1;
                            res_next.fired = 1'b1;
                            if (per_in_reg != '0)
                            begin
                                deadline_next = adv;
                                armed_next    = 1'b1;
                            end
                        end
                    end
                    else if (rel_sum[TW])
                    begin
                        res_next.status = STATUS_INVALID;
                    end
                    else
                    begin
                        deadline_next = rel_sum[TW-1:0];
                        armed_next    = 1'b1;
                    end
                end
                res_next.expiry_count = total_next;
            end
            OP_READ:
            begin
                if (total_reg == '0)
                begin
                    res_next.status = STATUS_WOULD_BLOCK;
                end
                else
                begin
                    res_next.expiry_count = total_reg;
                    total_next = '0;
                end
            end
            default:
            begin
                res_next.remaining_time = 64'(rem_old);
                res_next.period_out     = 64'(per_old);
                res_next.expiry_count   = total_reg;
            end
        endcase
        res_next.readable = (total_next != '0);
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            total_reg     <= '0;
            deadline_reg  <= '0;
            period_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd.commit)
            begin
                armed_reg    <= armed_next;
                total_reg    <= total_next;
                deadline_reg <= deadline_next;
                period_reg   <= period_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= item.operation;
            now_reg    <= item.now_time[TW-1:0];
            start_reg  <= item.start_value[TW-1:0];
            per_in_reg <= item.period_in[TW-1:0];
            abs_reg    <= item.absolute;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign status.need_div = need_div;
    assign status.div_busy = div_busy;
    assign status.out_free = !res_valid_reg || result_ready;
    assign result_valid    = res_valid_reg;
    assign result          = res_reg;

endmodule

>>> design/ptoc_ctrl.sv
// ----------------------------------------------------------------------------
// Timer controller
// Sequences capture, optional division and commit of each transaction.
// ----------------------------------------------------------------------------
module ptoc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  ptoc_pkg::dp_status_t status,
    output ptoc_pkg::dp_cmd_t    cmd
);
    import ptoc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = status.need_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready    = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            S_EVAL:
            begin
                cmd.div_start = status.need_div;
            end
            S_DONE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/periodic_timer_overrun_counter.sv
// Sequence: the item is captured, evaluated, divided when a periodic expiration
// needs the overrun division, and committed to the result register once it is free.
// Transactions are taken one at a time, the next only back in idle; the bit-serial
// divider in the datapath retires one quotient bit per cycle.
// Reset: rst_n clears the timer (disarmed, zero count, deadline and period)
// and empties the result register.
// ----------------------------------------------------------------------------
// Periodic timer overrun counter
// One-shot or periodic interval timer that counts expirations and overruns.
// ----------------------------------------------------------------------------
module periodic_timer_overrun_counter #(
    parameter int TIME_WIDTH = ptoc_pkg::DEF_TIME_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ptoc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ptoc_pkg::result_t result
);
    import ptoc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ptoc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ptoc_dp #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> test/ptoc_checker.sv
// ----------------------------------------------------------------------------
// Periodic timer overrun counter checker
// Watches the item and result channels. Each accepted item runs through a
// timer predictor, and the result it predicts goes into a FIFO. Each accepted
// result is compared field by field with the oldest prediction. Mismatches
// and pending predictions are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ptoc_checker #(
    parameter int TIME_WIDTH = ptoc_pkg::DEF_TIME_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  ptoc_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  ptoc_pkg::result_t result,
    output int                fail_count,
    output int                pending,
    output int                checked_count,
    output int                fired_count
);
    import ptoc_pkg::*;

    localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TIME_WIDTH);

    logic        timer_armed;
    logic [63:0] exp_total;
    logic [63:0] due_time;
    logic [63:0] rep_period;

    result_t     expected_results[$];
    int          mismatches;
    int          checked;
    int          fired_seen;

    function automatic logic [63:0] expirations_due(input logic [63:0] now_v,
                                                    input logic [63:0] due_v,
                                                    input logic [63:0] per_v);
        logic [63:0] cnt;
        cnt = 64'd1;
        if (per_v != 64'd0 && now_v > due_v)
            cnt = cnt + (now_v - due_v) / per_v;
        return cnt;
    endfunction

    function automatic void time_left(input  logic [63:0] now_v,
                                      output logic [63:0] rem,
                                      output logic [63:0] per);
        rem = 64'd0;
        per = 64'd0;
        if (timer_armed)
        begin
            if (due_time > now_v)
                rem = due_time - now_v;
            per = rep_period;
        end
    endfunction

    function automatic result_t apply_timer_op(input item_t it);
        logic [63:0] now_v;
        logic [63:0] start_v;
        logic [63:0] per_v;
        logic [63:0] cnt;
        logic [63:0] delay;
        logic        ok;
        result_t     r;
        r       = '0;
        now_v   = it.now_time & TMASK;
        start_v = it.start_value & TMASK;
        per_v   = it.period_in & TMASK;
        case (it.operation)
            OP_TICK:
            begin
                if (timer_armed && now_v >= due_time)
                begin
                    cnt = expirations_due(now_v, due_time, rep_period);
                    exp_total = exp_total + cnt;
                    if (rep_period != 64'd0)
                        due_time = (due_time + cnt * rep_period) & TMASK;
                    else
                        timer_armed = 1'b0;
                    r.fired = 1'b1;
                end
                r.expiry_count = exp_total;
            end
            OP_SET:
            begin
                time_left(now_v, r.remaining_time, r.period_out);
                timer_armed = 1'b0;
                exp_total   = 64'd0;
                rep_period  = per_v;
                if (start_v != 64'd0)
                begin
                    delay = 64'd0;
                    ok    = 1'b1;
                    if (it.absolute)
                    begin
                        due_time = start_v;
                        if (start_v > now_v)
                            delay = start_v - now_v;
                        else
                        begin
                            cnt = expirations_due(now_v, start_v, per_v);
                            exp_total = cnt;
                            r.fired = 1'b1;
                            if (per_v != 64'd0)
                                due_time = (start_v + cnt * per_v) & TMASK;
                        end
                    end
                    else if (TMASK - now_v < start_v)
                    begin
                        r.status = STATUS_INVALID;
                        ok = 1'b0;
                    end
                    else
                    begin
                        due_time = now_v + start_v;
                        delay = start_v;
                    end
                    if (ok && (delay != 64'd0 || per_v != 64'd0))
                        timer_armed = 1'b1;
                end
                r.expiry_count = exp_total;
            end
            OP_READ:
            begin
                if (exp_total == 64'd0)
                    r.status = STATUS_WOULD_BLOCK;
                else
                begin
                    r.expiry_count = exp_total;
                    exp_total = 64'd0;
                end
            end
            default:
            begin
                time_left(now_v, r.remaining_time, r.period_out);
                r.expiry_count = exp_total;
            end
        endcase
        r.readable = (exp_total != 64'd0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        logic    bad;
        if (!rst_n)
        begin
            timer_armed = 1'b0;
            exp_total   = 64'd0;
            due_time    = 64'd0;
            rep_period  = 64'd0;
            expected_results.delete();
            mismatches  = 0;
            checked     = 0;
            fired_seen  = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing pending: %p",
                                 $realtime, result);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (exp_r.fired)
                        fired_seen++;
                    bad = (result.status !== exp_r.status)
                       || (result.expiry_count !== exp_r.expiry_count)
                       || (result.remaining_time !== exp_r.remaining_time)
                       || (result.period_out !== exp_r.period_out)
                       || (result.fired !== exp_r.fired)
                       || (result.readable !== exp_r.readable);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch on result transaction %0d",
                                     $realtime, checked);
                            $display("  expected status=%0d count=%h rem=%h per=%h fired=%b rd=%b",
                                     exp_r.status, exp_r.expiry_count, exp_r.remaining_time,
                                     exp_r.period_out, exp_r.fired, exp_r.readable);
                            $display("  actual   status=%0d count=%h rem=%h per=%h fired=%b rd=%b",
                                     result.status, result.expiry_count, result.remaining_time,
                                     result.period_out, result.fired, result.readable);
                        end
                    end
                end
            end
            if (item_valid && item_ready)
                expected_results.push_back(apply_timer_op(item));
        end
        fail_count    <= mismatches;
        pending       <= expected_results.size();
        checked_count <= checked;
        fired_count   <= fired_seen;
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Periodic timer overrun counter testbench
// Drives directed timer sequences (disarmed ticks, one-shot and periodic
// expirations, overruns, zero start, past absolute sets, relative overflow,
// extreme times), then random traffic that follows a mostly advancing clock,
// under four pacing phases of sender idling and receiver stalling. A checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
    import ptoc_pkg::*;

    localparam int          TW       = DEF_TIME_WIDTH;
    localparam logic [63:0] MAX_TIME = {64{1'b1}};

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    int          fail_count;
    int          pending;
    int          checked_count;
    int          fired_count;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [63:0] wall_clock     = 64'd0;

    periodic_timer_overrun_counter #(.TIME_WIDTH(TW)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    ptoc_checker #(.TIME_WIDTH(TW)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .fired_count   (fired_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t mk(input logic [1:0] op, input logic [63:0] now_v,
                                 input logic [63:0] start_v, input logic [63:0] per_v,
                                 input logic abs_v);
        item_t it;
        it.operation   = op;
        it.now_time    = now_v;
        it.start_value = start_v;
        it.period_in   = per_v;
        it.absolute    = abs_v;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 80)
            wall_clock = wall_clock + 64'($urandom_range(0, 1500));
        else if (sel < 90)
            wall_clock = rand64();
        else if (sel < 95)
            wall_clock = MAX_TIME - 64'($urandom_range(0, 3000));
        else
            wall_clock = 64'($urandom_range(0, 3000));
        it.now_time = wall_clock;
        sel = $urandom_range(99);
        if (sel < 35)
            it.operation = OP_TICK;
        else if (sel < 60)
            it.operation = OP_SET;
        else if (sel < 80)
            it.operation = OP_READ;
        else
            it.operation = OP_GET;
        if (it.operation == OP_SET)
        begin
            it.absolute = 1'($urandom_range(1));
            sel = $urandom_range(99);
            if (sel < 8)
                it.start_value = 64'd0;
            else if (sel < 18)
                it.start_value = rand64();
            else if (it.absolute)
                it.start_value = wall_clock + 64'($urandom_range(0, 4000)) - 64'd2000;
            else
                it.start_value = 64'($urandom_range(1, 4000));
            sel = $urandom_range(99);
            if (sel < 20)
                it.period_in = 64'd0;
            else if (sel < 30)
                it.period_in = rand64();
            else if (sel < 40)
                it.period_in = 64'($urandom_range(1, 3));
            else
                it.period_in = 64'($urandom_range(1, 600));
        end
        else
        begin
            it.start_value = rand64();
            it.period_in   = rand64();
            it.absolute    = 1'($urandom_range(1));
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk(OP_TICK, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_READ, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_GET, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, 64'd1000, 64'd100, 64'd0, 1'b0));
        send_item(mk(OP_TICK, 64'd1050, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_GET, 64'd1050, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_TICK, 64'd1100, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_READ, 64'd1100, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, 64'd2000, 64'd10, 64'd7, 1'b0));
        send_item(mk(OP_TICK, 64'd2100, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_GET, 64'd2101, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, 64'd2200, 64'd0, 64'd55, 1'b0));
        send_item(mk(OP_GET, 64'd2200, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, 64'd3000, 64'd500, 64'd0, 1'b1));
        send_item(mk(OP_SET, MAX_TIME, 64'd1, 64'd1, 1'b1));
        send_item(mk(OP_READ, MAX_TIME, MAX_TIME, MAX_TIME, 1'b1));
        send_item(mk(OP_SET, 64'd4000, 64'd4050, 64'd20, 1'b1));
        send_item(mk(OP_SET, MAX_TIME - 64'd5, 64'd10, 64'd9, 1'b0));
        send_item(mk(OP_GET, MAX_TIME - 64'd5, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, MAX_TIME - 64'd10, 64'd10, 64'd0, 1'b0));
        send_item(mk(OP_TICK, MAX_TIME, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_READ, MAX_TIME, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_SET, 64'd0, MAX_TIME, MAX_TIME, 1'b1));
        send_item(mk(OP_TICK, MAX_TIME, 64'd0, 64'd0, 1'b0));
        send_item(mk(OP_GET, MAX_TIME, MAX_TIME, MAX_TIME, 1'b1));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int n = 0; n < 240; n++)
                send_item(random_item());
        end
        item_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("tb: %0d result transactions checked, %0d with expirations, %0d mismatches",
                 checked_count, fired_count, fail_count);
        $display("tb: directed timer cases plus random traffic under four pacing phases");
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
